// ===== sv/radar_view_coordinates_core_assert.svh =====
// assertion helpers shared by the rtl
`ifndef RADAR_VIEW_COORDINATES_CORE_ASSERT_SVH
`define RADAR_VIEW_COORDINATES_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvc check failed");

// implication whose consequent is checked in the next cycle
`define RVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvc check failed");

`endif

// ===== sv/rvc_pkg.sv =====
package rvc_pkg;

  localparam int unsigned CF = 20;
  localparam int unsigned CORDIC_ROUNDS = 20;

  typedef struct packed {
    logic signed [31:0] own_x;
    logic signed [31:0] own_y;
    logic signed [31:0] own_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } rvc_in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               degenerate;
  } rvc_out_t;

  // atan(2^-i)/pi in q20
  function automatic logic [18:0] atan_pi(input logic [4:0] i);
    logic [18:0] v;
    begin
      unique case (i)
        5'd0: v = 19'd262144;
        5'd1: v = 19'd154753;
        5'd2: v = 19'd81767;
        5'd3: v = 19'd41506;
        5'd4: v = 19'd20834;
        5'd5: v = 19'd10427;
        5'd6: v = 19'd5215;
        5'd7: v = 19'd2608;
        5'd8: v = 19'd1304;
        5'd9: v = 19'd652;
        5'd10: v = 19'd326;
        5'd11: v = 19'd163;
        5'd12: v = 19'd81;
        5'd13: v = 19'd41;
        5'd14: v = 19'd20;
        5'd15: v = 19'd10;
        5'd16: v = 19'd5;
        5'd17: v = 19'd3;
        5'd18: v = 19'd1;
        5'd19: v = 19'd1;
        default: v = 19'd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== sv/rvc_isqrt.sv =====
// pipelined floor square root, one result bit per stage
module rvc_isqrt #(
  parameter int unsigned IN_W = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [IN_W-1:0]       rad_i,
  output logic                  valid_o,
  output logic [(IN_W+1)/2-1:0] root_o
);
  localparam int unsigned OW = (IN_W + 1) / 2;
  localparam int unsigned RW = 2 * OW;

  logic [RW-1:0] rem_q  [OW+1];
  logic [RW-1:0] rad_q  [OW+1];
  logic [OW-1:0] root_q [OW+1];
  logic          vld_q  [OW+1];

  assign rem_q[0]  = '0;
  assign rad_q[0]  = RW'(rad_i);
  assign root_q[0] = '0;
  assign vld_q[0]  = valid_i;

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [RW+1:0] trial;
    logic [RW+1:0] cur;
    assign cur   = {rem_q[s], rad_q[s][RW-1 -: 2]};
    assign trial = {(RW + 2 - OW)'(0), root_q[s]} << 2 | (RW + 2)'(1);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1] <= rad_q[s] << 2;
      if (cur >= trial) begin
        rem_q[s+1]  <= RW'(cur - trial);
        root_q[s+1] <= {root_q[s][OW-2:0], 1'b1};
      end else begin
        rem_q[s+1]  <= RW'(cur);
        root_q[s+1] <= {root_q[s][OW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[OW];
  assign root_o  = root_q[OW];
endmodule

// ===== sv/rvc_divider.sv =====
// pipelined restoring divide with round half away and clamp to 2^20
module rvc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [56:0] num_i,
  input  logic [40:0] den_i,
  output logic        valid_o,
  output logic [20:0] quo_o
);
  localparam int unsigned QW = 22;
  localparam int unsigned NW = 57;

  logic [41:0]   rem_q [QW+1];
  logic [QW-1:0] num_q [QW+1];
  logic [40:0]   den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          big_q [QW+1];
  logic          vld_q [QW+1];
  logic [NW:0]   num_r;

  // numerator + den/2 for round half away
  assign num_r = {1'b0, num_i} + (NW + 1)'(den_i[40:1]);
  // the bits above the quotient width seed the remainder
  assign rem_q[0] = 42'(num_r[NW:QW]);
  assign num_q[0] = num_r[QW-1:0];
  assign den_q[0] = den_i;
  assign quo_q[0] = '0;
  // a quotient of 2^22 or more saturates
  assign big_q[0] = 41'(num_r[NW:QW]) >= den_i;
  assign vld_q[0] = valid_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [42:0] cur;
    assign cur = {rem_q[s], num_q[s][QW-1-s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      num_q[s+1] <= num_q[s];
      den_q[s+1] <= den_q[s];
      big_q[s+1] <= big_q[s];
      if (cur >= {2'd0, den_q[s]}) begin
        rem_q[s+1] <= 42'(cur - {2'd0, den_q[s]});
        quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= 42'(cur);
        quo_q[s+1] <= {quo_q[s][QW-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = (big_q[QW] || quo_q[QW] > QW'(21'h100000)) ? 21'h100000
                                                             : 21'(quo_q[QW]);
endmodule

// ===== sv/rvc_cordic.sv =====
// pipelined acos/pi, one vectoring round per stage
module rvc_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [20:0] x_i,
  input  logic [20:0] y_i,
  input  logic        neg_i,
  output logic        valid_o,
  output logic [20:0] r_o
);
  import rvc_pkg::*;

  logic signed [24:0] x_q [CORDIC_ROUNDS+1];
  logic signed [24:0] y_q [CORDIC_ROUNDS+1];
  logic signed [21:0] z_q [CORDIC_ROUNDS+1];
  logic               n_q [CORDIC_ROUNDS+1];
  logic               v_q [CORDIC_ROUNDS+1];

  assign x_q[0] = 25'($signed({1'b0, x_i}));
  assign y_q[0] = 25'($signed({1'b0, y_i}));
  assign z_q[0] = '0;
  assign n_q[0] = neg_i;
  assign v_q[0] = valid_i;

  for (genvar i = 0; i < CORDIC_ROUNDS; i++) begin : g_round
    logic signed [24:0] xs, ys;
    logic signed [21:0] a;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign a  = 22'($signed({3'd0, atan_pi(5'(i))}));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      n_q[i+1] <= n_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + a;
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - a;
      end
    end
  end

  logic [19:0] zc;
  always_comb begin
    priority if (z_q[CORDIC_ROUNDS] < 0) begin
      zc = '0;
    end else if (z_q[CORDIC_ROUNDS] > 22'sd524288) begin
      zc = 20'd524288;
    end else begin
      zc = 20'(z_q[CORDIC_ROUNDS]);
    end
  end

  assign valid_o = v_q[CORDIC_ROUNDS];
  assign r_o = n_q[CORDIC_ROUNDS] ? 21'(21'h100000 - {1'b0, zc}) : {1'b0, zc};
endmodule

// ===== sv/radar_view_coordinates_core.sv =====
// channel  | direction | handshake        | payload
// command  | in        | start_i / busy_o | cmd_i   (rvc_in_t)
// result   | out       | strobe_o         | result_o (rvc_out_t)
//
// an item can be accepted every cycle; busy_o is tied low
// each result passes nine front stages, the square root and divide chains,
// the squaring stage, square root and cordic chains and two output stages
// reset clears only the valid bits; results cannot be stalled
module radar_view_coordinates_core #(
  parameter int unsigned UNIT_FRAC_BITS = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  rvc_pkg::rvc_in_t  cmd_i,
  output logic              strobe_o,
  output rvc_pkg::rvc_out_t result_o
);
  import rvc_pkg::*;

  `include "radar_view_coordinates_core_assert.svh"

  localparam int unsigned U  = UNIT_FRAC_BITS;
  localparam int unsigned SH = 2 * CF - U;

  // depths of the isqrt, divider and cordic chains, used to align side data
  localparam int unsigned L_SQ46 = 23;
  localparam int unsigned L_DIV  = 22;
  localparam int unsigned L_SQ41 = 21;
  localparam int unsigned L_COR  = CORDIC_ROUNDS;

  assign busy_o = 1'b0;

  // ---------------- stage 1: difference, register f and u
  logic        v1_q;
  logic signed [32:0] d1_q [3];
  logic signed [15:0] f1_q [3], u1_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= start_i;
  end
  always_ff @(posedge clk_i) begin
    d1_q[0] <= 33'(cmd_i.target_x) - 33'(cmd_i.own_x);
    d1_q[1] <= 33'(cmd_i.target_y) - 33'(cmd_i.own_y);
    d1_q[2] <= 33'(cmd_i.target_z) - 33'(cmd_i.own_z);
    f1_q <= '{cmd_i.fwd_x, cmd_i.fwd_y, cmd_i.fwd_z};
    u1_q <= '{cmd_i.up_x, cmd_i.up_y, cmd_i.up_z};
  end

  // normalize magnitudes so the largest lies in [2^19, 2^20)
  function automatic logic [7:0] lead(input logic [63:0] t);
    logic [7:0] p;
    begin
      p = 8'd0;
      for (int k = 0; k < 64; k++) if (t[k]) p = 8'(k);
      return p;
    end
  endfunction

  function automatic logic signed [21:0] norm_one(input logic signed [63:0] v,
                                                  input logic [7:0] top);
    logic [63:0] m;
    logic [63:0] x;
    begin
      m = v[63] ? 64'(-v) : 64'(v);
      if (top >= 8'd19) x = m >> (top - 8'd19);
      else x = m << (8'd19 - top);
      return v[63] ? -$signed({1'b0, x[20:0]}) : $signed({1'b0, x[20:0]});
    end
  endfunction

  // ---------------- stage 2: normalize d
  logic        v2_q, z2_q;
  logic signed [21:0] e2_q [3];
  logic signed [15:0] f2_q [3], u2_q [3];
  logic [63:0] dm1 [3];
  logic [63:0] dtop1;
  always_comb begin
    for (int k = 0; k < 3; k++) dm1[k] = d1_q[k][32] ? 64'(-d1_q[k]) : 64'(d1_q[k]);
    dtop1 = dm1[0] | dm1[1] | dm1[2];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    z2_q <= (dtop1 == '0);
    for (int k = 0; k < 3; k++) e2_q[k] <= norm_one(64'(d1_q[k]), lead(dtop1));
    f2_q <= f1_q;
    u2_q <= u1_q;
  end

  // ---------------- stage 3: products f*e, u cross terms
  logic        v3_q, z3_q;
  logic signed [37:0] fe3_q [3];
  logic signed [32:0] cr3_q [3];
  logic signed [21:0] e3_q [3];
  logic signed [15:0] f3_q [3], u3_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    z3_q <= z2_q;
    for (int k = 0; k < 3; k++) fe3_q[k] <= 38'(f2_q[k]) * 38'(e2_q[k]);
    cr3_q[0] <= 33'(f2_q[1]) * 33'(u2_q[2]) - 33'(f2_q[2]) * 33'(u2_q[1]);
    cr3_q[1] <= 33'(f2_q[2]) * 33'(u2_q[0]) - 33'(f2_q[0]) * 33'(u2_q[2]);
    cr3_q[2] <= 33'(f2_q[0]) * 33'(u2_q[1]) - 33'(f2_q[1]) * 33'(u2_q[0]);
    e3_q <= e2_q;
    f3_q <= f2_q;
    u3_q <= u2_q;
  end

  // ---------------- stage 4: fd, sign products
  logic        v4_q, z4_q;
  logic signed [39:0] fd4_q;
  logic signed [55:0] sp4_q [3];
  logic signed [21:0] e4_q [3];
  logic signed [15:0] f4_q [3], u4_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    z4_q <= z3_q;
    fd4_q <= 40'(fe3_q[0]) + 40'(fe3_q[1]) + 40'(fe3_q[2]);
    for (int k = 0; k < 3; k++) sp4_q[k] <= 56'(cr3_q[k]) * 56'(e3_q[k]);
    e4_q <= e3_q;
    f4_q <= f3_q;
    u4_q <= u3_q;
  end

  // ---------------- stage 5: fd*f products, |e|^2 terms
  logic        v5_q, z5_q, sg5_q;
  logic signed [39:0] fd5_q;
  logic signed [63:0] fdf5_q [3];
  logic [43:0] esq5_q [3];
  logic signed [21:0] e5_q [3];
  logic signed [15:0] u5_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    z5_q <= z4_q;
    sg5_q <= (58'(sp4_q[0]) + 58'(sp4_q[1]) + 58'(sp4_q[2])) <= 0;
    fd5_q <= fd4_q;
    for (int k = 0; k < 3; k++) begin
      fdf5_q[k] <= 64'(fd4_q) * 64'(f4_q[k]);
      esq5_q[k] <= 44'(e4_q[k]) * 44'(e4_q[k]);
    end
    e5_q <= e4_q;
    u5_q <= u4_q;
  end

  // ---------------- stage 6: P = e*2^(2U) - fd*f, |e|^2
  logic        v6_q, z6_q, sg6_q;
  logic signed [39:0] fd6_q;
  logic signed [63:0] p6_q [3];
  logic [45:0] el6_q;
  logic signed [15:0] u6_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else v6_q <= v5_q;
  end
  always_ff @(posedge clk_i) begin
    z6_q <= z5_q;
    sg6_q <= sg5_q;
    fd6_q <= fd5_q;
    for (int k = 0; k < 3; k++) p6_q[k] <= (64'(e5_q[k]) <<< (2 * U)) - fdf5_q[k];
    el6_q <= 46'(esq5_q[0]) + 46'(esq5_q[1]) + 46'(esq5_q[2]);
    u6_q <= u5_q;
  end

  // ---------------- stage 7: normalize P
  logic        v7_q, z7_q, sg7_q;
  logic signed [39:0] fd7_q;
  logic signed [21:0] q7_q [3];
  logic [45:0] el7_q;
  logic signed [15:0] u7_q [3];
  logic [63:0] pm6 [3];
  logic [63:0] ptop6;
  always_comb begin
    for (int k = 0; k < 3; k++) pm6[k] = p6_q[k][63] ? 64'(-p6_q[k]) : 64'(p6_q[k]);
    ptop6 = pm6[0] | pm6[1] | pm6[2];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else v7_q <= v6_q;
  end
  always_ff @(posedge clk_i) begin
    z7_q <= z6_q || (ptop6 == '0);
    sg7_q <= sg6_q;
    fd7_q <= fd6_q;
    for (int k = 0; k < 3; k++) q7_q[k] <= norm_one(p6_q[k], lead(ptop6));
    el7_q <= el6_q;
    u7_q <= u6_q;
  end

  // ---------------- stage 8: |Q|^2 terms and u.Q terms
  logic        v8_q, z8_q, sg8_q;
  logic signed [39:0] fd8_q;
  logic [43:0] qsq8_q [3];
  logic signed [37:0] uq8_q [3];
  logic [45:0] el8_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v8_q <= 1'b0;
    else v8_q <= v7_q;
  end
  always_ff @(posedge clk_i) begin
    z8_q <= z7_q;
    sg8_q <= sg7_q;
    fd8_q <= fd7_q;
    for (int k = 0; k < 3; k++) begin
      qsq8_q[k] <= 44'(q7_q[k]) * 44'(q7_q[k]);
      uq8_q[k] <= 38'(u7_q[k]) * 38'(q7_q[k]);
    end
    el8_q <= el7_q;
  end

  // ---------------- stage 9: sums
  logic        v9_q, z9_q, sg9_q;
  logic signed [39:0] fd9_q, ud9_q;
  logic [45:0] ql9_q, el9_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v9_q <= 1'b0;
    else v9_q <= v8_q;
  end
  always_ff @(posedge clk_i) begin
    z9_q <= z8_q;
    sg9_q <= sg8_q;
    fd9_q <= fd8_q;
    ud9_q <= 40'(uq8_q[0]) + 40'(uq8_q[1]) + 40'(uq8_q[2]);
    ql9_q <= 46'(qsq8_q[0]) + 46'(qsq8_q[1]) + 46'(qsq8_q[2]);
    el9_q <= el8_q;
  end

  // ---------------- lengths
  logic        vs_o;
  logic [22:0] qlen, elen;
  rvc_isqrt #(.IN_W(46)) u_sq_q (
    .clk_i, .rst_ni, .valid_i(v9_q), .rad_i(ql9_q), .valid_o(vs_o), .root_o(qlen)
  );
  rvc_isqrt #(.IN_W(46)) u_sq_e (
    .clk_i, .rst_ni, .valid_i(v9_q), .rad_i(el9_q), .valid_o(), .root_o(elen)
  );

  // side data delay across the isqrt chain
  logic signed [39:0] fdA_q [L_SQ46], udA_q [L_SQ46];
  logic               zA_q [L_SQ46], sgA_q [L_SQ46];
  always_ff @(posedge clk_i) begin
    fdA_q[0] <= fd9_q; udA_q[0] <= ud9_q; zA_q[0] <= z9_q; sgA_q[0] <= sg9_q;
    for (int k = 1; k < L_SQ46; k++) begin
      fdA_q[k] <= fdA_q[k-1]; udA_q[k] <= udA_q[k-1];
      zA_q[k] <= zA_q[k-1]; sgA_q[k] <= sgA_q[k-1];
    end
  end
  logic signed [39:0] fdA, udA;
  logic zA, sgA;
  assign fdA = fdA_q[L_SQ46-1];
  assign udA = udA_q[L_SQ46-1];
  assign zA  = zA_q[L_SQ46-1];
  assign sgA = sgA_q[L_SQ46-1];

  // ---------------- cosines
  logic [56:0] num1, num2;
  logic [40:0] den1, den2;
  assign num1 = 57'(udA[39] ? -udA : udA) << CF;
  assign num2 = 57'(fdA[39] ? -fdA : fdA) << CF;
  assign den1 = 41'({18'd0, qlen} << U);
  assign den2 = 41'({18'd0, elen} << U);

  logic        vd_o;
  logic [20:0] c1m, c2m;
  rvc_divider u_div1 (
    .clk_i, .rst_ni, .valid_i(vs_o), .num_i(num1), .den_i(den1),
    .valid_o(vd_o), .quo_o(c1m)
  );
  rvc_divider u_div2 (
    .clk_i, .rst_ni, .valid_i(vs_o), .num_i(num2), .den_i(den2),
    .valid_o(), .quo_o(c2m)
  );

  logic n1B_q [L_DIV], n2B_q [L_DIV], zB_q [L_DIV], sgB_q [L_DIV];
  always_ff @(posedge clk_i) begin
    n1B_q[0] <= udA[39]; n2B_q[0] <= fdA[39]; zB_q[0] <= zA; sgB_q[0] <= sgA;
    for (int k = 1; k < L_DIV; k++) begin
      n1B_q[k] <= n1B_q[k-1]; n2B_q[k] <= n2B_q[k-1];
      zB_q[k] <= zB_q[k-1]; sgB_q[k] <= sgB_q[k-1];
    end
  end

  // ---------------- squares of cosines
  logic        vC_q, n1C_q, n2C_q, zC_q, sgC_q;
  logic [20:0] c1C_q, c2C_q;
  logic [40:0] s1r_q, s2r_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vC_q <= 1'b0;
    else vC_q <= vd_o;
  end
  always_ff @(posedge clk_i) begin
    n1C_q <= n1B_q[L_DIV-1]; n2C_q <= n2B_q[L_DIV-1];
    zC_q <= zB_q[L_DIV-1]; sgC_q <= sgB_q[L_DIV-1];
    c1C_q <= c1m; c2C_q <= c2m;
    s1r_q <= 41'(42'h100_0000_0000 - 42'(c1m) * 42'(c1m));
    s2r_q <= 41'(42'h100_0000_0000 - 42'(c2m) * 42'(c2m));
  end

  logic        vE;
  logic [20:0] s1, s2;
  rvc_isqrt #(.IN_W(41)) u_sq_s1 (
    .clk_i, .rst_ni, .valid_i(vC_q), .rad_i(s1r_q), .valid_o(vE), .root_o(s1)
  );
  rvc_isqrt #(.IN_W(41)) u_sq_s2 (
    .clk_i, .rst_ni, .valid_i(vC_q), .rad_i(s2r_q), .valid_o(), .root_o(s2)
  );

  logic [20:0] c1E_q [L_SQ41], c2E_q [L_SQ41];
  logic        n1E_q [L_SQ41], n2E_q [L_SQ41], zE_q [L_SQ41], sgE_q [L_SQ41];
  always_ff @(posedge clk_i) begin
    c1E_q[0] <= c1C_q; c2E_q[0] <= c2C_q; n1E_q[0] <= n1C_q; n2E_q[0] <= n2C_q;
    zE_q[0] <= zC_q; sgE_q[0] <= sgC_q;
    for (int k = 1; k < L_SQ41; k++) begin
      c1E_q[k] <= c1E_q[k-1]; c2E_q[k] <= c2E_q[k-1];
      n1E_q[k] <= n1E_q[k-1]; n2E_q[k] <= n2E_q[k-1];
      zE_q[k] <= zE_q[k-1]; sgE_q[k] <= sgE_q[k-1];
    end
  end

  // ---------------- radius
  logic        vR;
  logic [20:0] rad;
  rvc_cordic u_cordic (
    .clk_i, .rst_ni, .valid_i(vE), .x_i(c2E_q[L_SQ41-1]), .y_i(s2),
    .neg_i(n2E_q[L_SQ41-1] && c2E_q[L_SQ41-1] != '0), .valid_o(vR), .r_o(rad)
  );

  logic [20:0] s1F_q [L_COR], c1F_q [L_COR];
  logic        n1F_q [L_COR], zF_q [L_COR], sgF_q [L_COR];
  always_ff @(posedge clk_i) begin
    s1F_q[0] <= s1; c1F_q[0] <= c1E_q[L_SQ41-1]; n1F_q[0] <= n1E_q[L_SQ41-1];
    zF_q[0] <= zE_q[L_SQ41-1]; sgF_q[0] <= sgE_q[L_SQ41-1];
    for (int k = 1; k < L_COR; k++) begin
      s1F_q[k] <= s1F_q[k-1]; c1F_q[k] <= c1F_q[k-1]; n1F_q[k] <= n1F_q[k-1];
      zF_q[k] <= zF_q[k-1]; sgF_q[k] <= sgF_q[k-1];
    end
  end

  // ---------------- scale outputs
  logic        vG_q, zG_q, sgG_q, n1G_q;
  logic [41:0] px_q, py_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vG_q <= 1'b0;
    else vG_q <= vR;
  end
  always_ff @(posedge clk_i) begin
    zG_q <= zF_q[L_COR-1]; sgG_q <= sgF_q[L_COR-1];
    n1G_q <= n1F_q[L_COR-1] && c1F_q[L_COR-1] != '0;
    px_q <= 42'(s1F_q[L_COR-1]) * 42'(rad);
    py_q <= 42'(c1F_q[L_COR-1]) * 42'(rad);
  end

  function automatic logic [15:0] fin(input logic [41:0] p, input logic neg);
    logic [42:0] q;
    logic [16:0] m;
    logic signed [17:0] v;
    begin
      q = (43'(p) + (43'(1) << (SH - 1))) >> SH;
      m = (q > 43'd32768) ? 17'd32768 : 17'(q);
      v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
      if (v > 18'sd32767) v = 18'sd32767;
      return 16'(v);
    end
  endfunction

  logic     str_q;
  rvc_out_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) str_q <= 1'b0;
    else str_q <= vG_q;
  end
  always_ff @(posedge clk_i) begin
    if (zG_q) begin
      res_q <= '{screen_x: '0, screen_y: '0, degenerate: 1'b1};
    end else begin
      res_q <= '{screen_x: fin(px_q, sgG_q), screen_y: fin(py_q, n1G_q),
                 degenerate: 1'b0};
    end
  end

  assign strobe_o = str_q;
  assign result_o = res_q;

  `RVC_ASSERT_IMP(a_busy_low, clk_i, rst_ni, 1'b1, !busy_o)
  `RVC_ASSERT_NEXT(a_strobe_follows, clk_i, rst_ni, vG_q, strobe_o)
  `RVC_ASSERT_IMP(a_degen_zero, clk_i, rst_ni, strobe_o && result_o.degenerate, result_o.screen_x == '0 && result_o.screen_y == '0)
endmodule
